// ===== design/echo_pulse_distance_meter_macros.svh =====
// Assertion macros of the echo pulse distance meter, used by epdm_fsm.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef ECHO_PULSE_DISTANCE_METER_MACROS_SVH
`define ECHO_PULSE_DISTANCE_METER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define EPDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define EPDM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define EPDM_ASSERT(lbl, prop, msg)
`define EPDM_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== design/epdm_pkg.sv =====
// Shared types, codes and constants of the echo pulse distance meter.
// Used by every module of the block; depends on nothing.
package epdm_pkg;

  localparam int CounterBitsDef = 16;

  localparam int StampW = 16;
  localparam int DistW  = 14;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [StampW-1:0] TimerTopRst = 16'hFFFF;
  localparam logic [DistW-1:0]  MinDistRst  = 14'd20;
  localparam logic [DistW-1:0]  MaxDistRst  = 14'd4000;

  // Distance is (w*343 + 1000) / 2000, done as a shift by four followed by
  // a reciprocal multiply for the remaining division by 125.
  localparam int SoundMmPerMs = 343;
  localparam int RoundHalf    = 1000;
  localparam int RecipShift   = 28;
  localparam logic [21:0] Recip125 = 22'd2147484;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ABORT = 2'd1,
    CMD_EDGE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_RISE = 2'd1,
    PH_WAIT_FALL = 2'd2,
    PH_DONE      = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMER_TOP = 2'd0,
    REG_MIN_DIST  = 2'd1,
    REG_MAX_DIST  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [StampW-1:0] timer_top;
    logic [DistW-1:0]  min_dist;
    logic [DistW-1:0]  max_dist;
  } cfg_t;

  typedef struct packed {
    logic              in_range;
    logic [StampW-1:0] pulse_us;
    logic [DistW-1:0]  distance_mm;
  } meas_t;

  typedef struct packed {
    logic [DistW-1:0]  distance_mm;
    logic [StampW-1:0] pulse_us;
    logic              in_range;
    logic              ready_res;
    logic [1:0]        phase;
    logic              fire_trigger;
    logic              start_accepted;
  } res_t;

endpackage

// ===== design/epdm_meas.sv =====
// Pulse width, distance and range check for one falling edge.
// Purely combinational; depends on epdm_pkg.
module epdm_meas import epdm_pkg::*; #(
  parameter int CounterBits = CounterBitsDef,
  localparam int MaskW = (CounterBits < StampW) ? CounterBits : StampW
) (
  input  logic [MaskW-1:0]  rise_i,
  input  logic [StampW-1:0] fall_i,
  input  cfg_t              cfg_i,
  output meas_t             meas_o
);

  logic [MaskW-1:0]  fall_m;
  logic [MaskW-1:0]  top_m;
  logic [StampW-1:0] rise16;
  logic [StampW-1:0] fall16;
  logic [StampW-1:0] top16;
  logic [StampW-1:0] width;
  logic [24:0]       scaled;
  logic [20:0]       by16;
  logic [42:0]       quot;
  logic [DistW-1:0]  dist_mm;

  always_comb begin
    fall_m = fall_i[MaskW-1:0];
    top_m  = cfg_i.timer_top[MaskW-1:0];
    rise16 = StampW'(rise_i);
    fall16 = StampW'(fall_m);
    top16  = StampW'(top_m);
    if (fall16 >= rise16) begin
      width = fall16 - rise16;
    end else begin
      width = top16 + 16'd1 + fall16 - rise16;
    end
    scaled  = 25'(width) * 25'(SoundMmPerMs) + 25'(RoundHalf);
    by16    = scaled[24:4];
    quot    = 43'(by16) * 43'(Recip125);
    dist_mm = quot[RecipShift+DistW-1:RecipShift];
    meas_o.pulse_us    = width;
    meas_o.distance_mm = dist_mm;
    meas_o.in_range    = (dist_mm >= cfg_i.min_dist) && (dist_mm <= cfg_i.max_dist);
  end

endmodule

// ===== design/epdm_fsm.sv =====
// Measurement phase control, stored results and the result register.
// Depends on epdm_pkg, epdm_meas and the assertion macro header.
`include "echo_pulse_distance_meter_macros.svh"

module epdm_fsm import epdm_pkg::*; #(
  parameter int CounterBits = CounterBitsDef,
  localparam int MaskW = (CounterBits < StampW) ? CounterBits : StampW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [1:0]        cmd_i,
  input  logic [StampW-1:0] stamp_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  phase_e            phase_q, phase_d;
  logic [MaskW-1:0]  rise_q, rise_d;
  logic              ready_q, ready_d;
  logic              range_q, range_d;
  logic [StampW-1:0] width_q, width_d;
  logic [DistW-1:0]  dist_q, dist_d;
  logic              taken;
  meas_t             meas;
  res_t              res_q, res_d;

  epdm_meas #(.CounterBits(CounterBits)) u_meas (
    .rise_i (rise_q),
    .fall_i (stamp_i),
    .cfg_i  (cfg_i),
    .meas_o (meas)
  );

  always_comb begin
    phase_d = phase_q;
    rise_d  = rise_q;
    ready_d = ready_q;
    range_d = range_q;
    width_d = width_q;
    dist_d  = dist_q;
    taken   = 1'b0;
    case (cmd_i)
      CMD_START: begin
        if (phase_q inside {PH_IDLE, PH_DONE}) begin
          ready_d = 1'b0;
          range_d = 1'b0;
          width_d = '0;
          dist_d  = '0;
          phase_d = PH_WAIT_RISE;
          taken   = 1'b1;
        end
      end
      CMD_ABORT: begin
        phase_d = PH_IDLE;
        ready_d = 1'b0;
        range_d = 1'b0;
      end
      CMD_EDGE: begin
        if (phase_q == PH_WAIT_RISE) begin
          rise_d  = stamp_i[MaskW-1:0];
          phase_d = PH_WAIT_FALL;
        end else if (phase_q == PH_WAIT_FALL) begin
          width_d = meas.pulse_us;
          dist_d  = meas.distance_mm;
          range_d = meas.in_range;
          ready_d = 1'b1;
          phase_d = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    res_d.start_accepted = taken;
    res_d.fire_trigger   = taken;
    res_d.phase          = phase_d;
    res_d.ready_res      = ready_d;
    res_d.in_range       = range_d;
    res_d.pulse_us       = width_d;
    res_d.distance_mm    = dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rise_q  <= '0;
      ready_q <= 1'b0;
      range_q <= 1'b0;
      width_q <= '0;
      dist_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      rise_q  <= rise_d;
      ready_q <= ready_d;
      range_q <= range_d;
      width_q <= width_d;
      dist_q  <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  `EPDM_ASSERT(a_ready_done, ready_q == (phase_q == PH_DONE), "ready flag out of step with phase")
  `EPDM_ASSERT(a_range_ready, range_q |-> ready_q, "in-range flag set without a result")
  `EPDM_ASSERT_NEXT(a_start_arms, adv_i && cmd_i == CMD_START && (phase_q == PH_IDLE || phase_q == PH_DONE), phase_q == PH_WAIT_RISE && !ready_q && width_q == '0, "start did not arm")
  `EPDM_ASSERT_NEXT(a_start_blocked, adv_i && cmd_i == CMD_START && (phase_q == PH_WAIT_RISE || phase_q == PH_WAIT_FALL), !res_q.start_accepted && $stable(phase_q), "start taken while waiting")

endmodule

// ===== design/echo_pulse_distance_meter.sv =====
// Top level of the echo pulse distance meter: configuration registers,
// input register and result handshake. Depends on epdm_pkg and epdm_fsm.
//
// Use: each transaction on the s_axis channel carries one event, a start,
// an abort or a captured echo edge with its timer stamp. Every event gives
// exactly one result transaction on m_axis: whether a start was taken (and
// so a trigger pulse is requested), the phase after the event, the done and
// in-range flags and the stored pulse width and distance.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i in one cycle, with no read-back; they should be changed only
// while no event is in flight.
// An event waits in the input register until the result register can
// take it, and its result is valid once in the result register.
// Throughput: one event per cycle while the receiver does not stall; the
// width, distance and range check are done by one pass of logic between
// the two registers. Reset clears the phase to idle, the stored results,
// and loads the register defaults. When the receiver stalls, the result
// register holds, and the input register takes one more event only if
// it is empty; then tready drops.
module echo_pulse_distance_meter import epdm_pkg::*; #(
  parameter int CounterBits = CounterBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd [1:0], edge_stamp [17:2], zero fill [23:18]
  input  logic [23:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // start_accepted [0], fire_trigger [1], phase [3:2], ready_res [4],
  // in_range [5], pulse_us [21:6], distance_mm [35:22], zero fill [39:36]
  output logic [39:0]         m_axis_tdata
);

  cfg_t              cfg_q;
  logic              in_valid_q;
  logic [1:0]        cmd_q;
  logic [StampW-1:0] stamp_q;
  logic              out_valid_q;
  logic              adv;
  res_t              res;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_top <= TimerTopRst;
      cfg_q.min_dist  <= MinDistRst;
      cfg_q.max_dist  <= MaxDistRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIMER_TOP: cfg_q.timer_top <= cfg_data_i;
        REG_MIN_DIST:  cfg_q.min_dist  <= cfg_data_i[DistW-1:0];
        REG_MAX_DIST:  cfg_q.max_dist  <= cfg_data_i[DistW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q   <= s_axis_tdata[1:0];
      stamp_q <= s_axis_tdata[17:2];
    end
  end

  epdm_fsm #(.CounterBits(CounterBits)) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cmd_i   (cmd_q),
    .stamp_i (stamp_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res};

endmodule

// ===== dv/tb_top.sv =====
// Testbench for echo_pulse_distance_meter: drives start, abort, echo edge and
// reserved events, predicts every result transaction and checks it field by field.
// Depends on epdm_pkg and the echo_pulse_distance_meter RTL.
module tb_top;
  import epdm_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int ResetCycles = 8;
  localparam int SettleCycles = 6;
  localparam int HoldOffCycles = 60;
  localparam int EventsPerPhase = 140;
  localparam int RandomPhases = 8;
  localparam int CycleLimit = 200000;
  localparam int RoundDiv = 2000;
  localparam logic [1:0] CmdReserved = 2'd3;

  class ranging_scoreboard;
    logic [StampW-1:0] timer_top;
    logic [DistW-1:0] lo_mm;
    logic [DistW-1:0] hi_mm;
    phase_e phase;
    logic [StampW-1:0] rise_stamp;
    logic done_flag;
    logic range_flag;
    logic [StampW-1:0] width_us;
    logic [DistW-1:0] dist_mm;
    res_t expected_readings[$];
    int unsigned errors;

    function new();
      timer_top = TimerTopRst;
      lo_mm = MinDistRst;
      hi_mm = MaxDistRst;
      phase = PH_IDLE;
      rise_stamp = '0;
      done_flag = 1'b0;
      range_flag = 1'b0;
      width_us = '0;
      dist_mm = '0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_TIMER_TOP: timer_top = val;
        REG_MIN_DIST: lo_mm = val[DistW-1:0];
        REG_MAX_DIST: hi_mm = val[DistW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction

    function void note_event(logic [1:0] cmd, logic [StampW-1:0] stamp);
      res_t r;
      logic taken;
      logic [31:0] scaled;
      taken = 1'b0;
      case (cmd)
        CMD_START: begin
          if (phase == PH_IDLE || phase == PH_DONE) begin
            done_flag = 1'b0;
            range_flag = 1'b0;
            width_us = '0;
            dist_mm = '0;
            phase = PH_WAIT_RISE;
            taken = 1'b1;
          end
        end
        CMD_ABORT: begin
          phase = PH_IDLE;
          done_flag = 1'b0;
          range_flag = 1'b0;
        end
        CMD_EDGE: begin
          if (phase == PH_WAIT_RISE) begin
            rise_stamp = stamp;
            phase = PH_WAIT_FALL;
          end else if (phase == PH_WAIT_FALL) begin
            if (stamp >= rise_stamp) begin
              width_us = stamp - rise_stamp;
            end else begin
              width_us = timer_top + 16'd1 + stamp - rise_stamp;
            end
            scaled = (32'(width_us) * SoundMmPerMs + RoundHalf) / RoundDiv;
            dist_mm = scaled[DistW-1:0];
            range_flag = (dist_mm >= lo_mm) && (dist_mm <= hi_mm);
            done_flag = 1'b1;
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
      r.start_accepted = taken;
      r.fire_trigger = taken;
      r.phase = phase;
      r.ready_res = done_flag;
      r.in_range = range_flag;
      r.pulse_us = width_us;
      r.distance_mm = dist_mm;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_readings.size() == 0) begin
        $error("result transaction with no event waiting for it");
        errors++;
        return;
      end
      exp_r = expected_readings.pop_front();
      compare_field("start_accepted", exp_r.start_accepted, got.start_accepted);
      compare_field("fire_trigger", exp_r.fire_trigger, got.fire_trigger);
      compare_field("phase", exp_r.phase, got.phase);
      compare_field("ready_res", exp_r.ready_res, got.ready_res);
      compare_field("in_range", exp_r.in_range, got.in_range);
      compare_field("pulse_us", exp_r.pulse_us, got.pulse_us);
      compare_field("distance_mm", exp_r.distance_mm, got.distance_mm);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // cmd [1:0], edge_stamp [17:2], zero fill [23:18]
  logic [23:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // start_accepted [0], fire_trigger [1], phase [3:2], ready_res [4],
  // in_range [5], pulse_us [21:6], distance_mm [35:22], zero fill [39:36]
  logic [39:0] m_axis_tdata;

  ranging_scoreboard sb = new();
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit sink_hold_req = 1'b0;
  int unsigned events_sent = 0;
  int unsigned cycles = 0;

  echo_pulse_distance_meter dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_event(logic [1:0] cmd, logic [StampW-1:0] stamp);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, stamp, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(cmd, stamp);
    events_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [StampW-1:0] top, logic [DistW-1:0] lo,
                              logic [DistW-1:0] hi);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_TIMER_TOP;
    cfg_data_i <= top;
    @(posedge clk_i);
    cfg_idx_i <= REG_MIN_DIST;
    cfg_data_i <= {2'b00, lo};
    @(posedge clk_i);
    cfg_idx_i <= REG_MAX_DIST;
    cfg_data_i <= {2'b00, hi};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(REG_TIMER_TOP, top);
    sb.set_reg(REG_MIN_DIST, {2'b00, lo});
    sb.set_reg(REG_MAX_DIST, {2'b00, hi});
  endtask

  function automatic logic [StampW-1:0] draw_stamp();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, sb.timer_top));
  endfunction

  task automatic echo_burst();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      send_event(CMD_START, draw_stamp());
      send_event(CMD_EDGE, draw_stamp());
      if ($urandom_range(0, 7) == 0) begin
        send_event($urandom_range(0, 1) ? CMD_START : CmdReserved, draw_stamp());
      end
      if (pick <= 5) begin
        send_event(CMD_EDGE, draw_stamp());
      end else begin
        send_event($urandom_range(0, 1) ? CMD_ABORT : CMD_START, draw_stamp());
      end
    end else begin
      send_event(2'($urandom_range(0, 3)), 16'($urandom));
    end
  endtask

  initial begin : result_sink
    res_t got;
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[35:0];
      sb.check_result(got);
      if (sink_hold_req) begin
        stall = HoldOffCycles;
        sink_hold_req = 1'b0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned lo;
    int unsigned hi;
    bit paused;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_TIMER_TOP;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    paused = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(CMD_EDGE, 16'h1234);
    send_event(CMD_ABORT, 16'hFFFF);
    send_event(CmdReserved, 16'hFFFF);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_START, 16'hAAAA);
    send_event(CMD_EDGE, 16'h0000);
    send_event(CMD_START, 16'h5555);
    send_event(CMD_EDGE, 16'hFFFF);
    send_event(CMD_EDGE, 16'h0F0F);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_EDGE, 16'hFFF0);
    send_event(CMD_EDGE, 16'h0100);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_EDGE, 16'd1000);
    send_event(CmdReserved, 16'h0000);
    send_event(CMD_ABORT, 16'h0000);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_EDGE, 16'd5000);
    send_event(CMD_EDGE, 16'd5000);
    drain_results();
    program_regs(16'd999, 14'd16383, 14'd0);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_EDGE, 16'd60000);
    send_event(CMD_EDGE, 16'd500);
    drain_results();
    program_regs(16'd0, 14'd47, 14'd47);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_EDGE, 16'd100);
    send_event(CMD_EDGE, 16'd372);
    send_event(CMD_START, 16'h0000);
    send_event(CMD_EDGE, 16'd7);
    send_event(CMD_EDGE, 16'd3);

    for (int p = 0; p < RandomPhases; p++) begin
      drain_results();
      case (p)
        0: program_regs(16'hFFFF, 14'd0, 14'd16383);
        1: program_regs(16'd0, 14'd16383, 14'd16383);
        2: program_regs(TimerTopRst, MinDistRst, MaxDistRst);
        default: begin
          lo = $urandom_range(0, 3000);
          hi = $urandom_range(lo, 12000);
          if ($urandom_range(0, 4) == 0) begin
            program_regs(16'($urandom_range(0, 255)), 14'(hi), 14'(lo));
          end else if ($urandom_range(0, 2) == 0) begin
            program_regs(16'hFFFF, 14'(lo), 14'(hi));
          end else begin
            program_regs(16'($urandom), 14'(lo), 14'(hi));
          end
        end
      endcase
      tx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
      rx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
      if (p == 3) sink_hold_req = 1'b1;
      target = events_sent + EventsPerPhase;
      while (events_sent < target) begin
        echo_burst();
        if (p == 5 && !paused && events_sent + EventsPerPhase / 2 >= target) begin
          paused = 1'b1;
          drain_results();
        end
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/epdm_pkg.sv
design/epdm_meas.sv
design/epdm_fsm.sv
design/echo_pulse_distance_meter.sv
dv/tb_top.sv
